[hdl/bmrq_pkg.sv]
// bmrq_pkg: action and status codes for the multilevel ready queue.
// No dependencies; used by bitmap_multilevel_ready_queue_core.
package bmrq_pkg;

    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_ADD_BACK  = 2'd0;
    localparam action_t ACT_ADD_FRONT = 2'd1;
    localparam action_t ACT_REMOVE    = 2'd2;
    localparam action_t ACT_NONE      = 2'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

[hdl/bitmap_multilevel_ready_queue_core.sv]
// bitmap_multilevel_ready_queue_core: per-level task rings in a pointer memory and
// a task memory, bitmap of non-empty levels, front-task cache. Uses bmrq_pkg.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   action, task_id and level are sampled there. busy is high in the S_PTR and
//   S_FRONT states that follow acceptance. As busy falls, done is high for exactly
//   one cycle with ready_res, next_task, next_level, level_map and status; a new
//   start is taken in that same cycle, and not while busy is high.
//   The pointer memory is read at the accepting edge; the first busy cycle
//   updates pointers, writes the task memory and, on a remove, reads the new
//   front slot; the front cache and the result registers load at the end of
//   the second busy cycle.
//   The pointer memory read-modify-write of one transaction finishes before the
//   next read is issued, so no forwarding path into it is needed.
//   Reset (rst_n low, asynchronous) empties every level at once through per-level
//   valid bits; the task memory is not cleared and no sweep is run.
//   The receiver cannot stall: results are presented once and not held.
module bitmap_multilevel_ready_queue_core #(
    parameter int LEVELS     = 16,
    parameter int RING_DEPTH = 8,
    parameter int TASK_BITS  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [7:0]  task_id,
    input  logic [3:0]  level,
    output logic        done,
    output logic        ready_res,
    output logic [7:0]  next_task,
    output logic [3:0]  next_level,
    output logic [15:0] level_map,
    output logic [1:0]  status
);

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SLOTS  = LEVELS * RING_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PTR   = 2'd1;
    localparam logic [1:0] S_FRONT = 2'd2;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } ring_ptr_t;

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] pos);
        step_up = (pos == PTR_W'(RING_DEPTH - 1)) ? '0 : pos + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] pos);
        step_down = (pos == '0) ? PTR_W'(RING_DEPTH - 1) : pos - PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot(input logic [LVL_W-1:0] lvl,
                                               input logic [PTR_W-1:0] pos);
        slot = ADDR_W'(lvl) * ADDR_W'(RING_DEPTH) + ADDR_W'(pos);
    endfunction

    ring_ptr_t              ptr_mem [LEVELS];
    logic [TASK_BITS-1:0]   store_mem [SLOTS];
    logic [TASK_BITS-1:0]   front_mem [LEVELS];

    logic [1:0]             state_reg, state_next;
    bmrq_pkg::action_t      act_reg;
    logic [TASK_BITS-1:0]   tid_reg;
    logic [LVL_W-1:0]       lvl_reg;
    logic                   lvl_ok_reg;
    logic [LEVELS-1:0]      ptr_vld_reg;
    logic                   rd_vld_reg;
    ring_ptr_t              ptr_rd_reg;
    logic [LEVELS-1:0]      map_reg, map_next;
    bmrq_pkg::status_t      st_reg, st_next;
    logic                   fupd_reg, fupd_next;
    logic                   fmem_reg, fmem_next;
    logic [TASK_BITS-1:0]   store_rd_reg;

    logic                   done_reg;
    logic                   ready_reg;
    logic [TASK_BITS-1:0]   task_reg;
    logic [LVL_W-1:0]       nlvl_reg;
    logic [LEVELS-1:0]      lmap_reg;
    bmrq_pkg::status_t      status_reg;

    logic                   accept;
    logic                   in_lvl_ok;
    logic [LVL_W-1:0]       in_lvl;
    ring_ptr_t              cur, upd;
    logic                   ptr_we, store_we;
    logic [ADDR_W-1:0]      store_wa, store_ra;
    logic [LVL_W-1:0]       win;
    logic [TASK_BITS-1:0]   new_front, win_task;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign in_lvl    = level[LVL_W-1:0];
    assign in_lvl_ok = (5'(level) < 5'(LEVELS));
    assign cur       = rd_vld_reg ? ptr_rd_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_PTR : S_IDLE;
            S_PTR:   state_next = S_FRONT;
            S_FRONT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Pointer update, bitmap and status, and task memory access for the addressed level
    always_comb
    begin
        upd       = cur;
        map_next  = map_reg;
        st_next   = bmrq_pkg::ST_DONE;
        fupd_next = 1'b0;
        fmem_next = 1'b0;
        ptr_we    = 1'b0;
        store_we  = 1'b0;
        store_wa  = slot(lvl_reg, cur.tail);
        store_ra  = slot(lvl_reg, step_up(cur.head));
        unique case (act_reg) inside
            bmrq_pkg::ACT_ADD_BACK, bmrq_pkg::ACT_ADD_FRONT:
            begin
                if (!lvl_ok_reg || cur.count == CNT_W'(RING_DEPTH)) begin
                    st_next = bmrq_pkg::ST_FULL;
                end else begin
                    ptr_we    = 1'b1;
                    store_we  = 1'b1;
                    upd.count = cur.count + CNT_W'(1);
                    map_next[lvl_reg] = 1'b1;
                    if (act_reg == bmrq_pkg::ACT_ADD_BACK) begin
                        upd.tail  = step_up(cur.tail);
                        fupd_next = (cur.count == '0);
                    end else begin
                        upd.head  = step_down(cur.head);
                        store_wa  = slot(lvl_reg, step_down(cur.head));
                        fupd_next = 1'b1;
                    end
                end
            end
            bmrq_pkg::ACT_REMOVE:
            begin
                if (!lvl_ok_reg || cur.count == '0) begin
                    st_next = bmrq_pkg::ST_EMPTY;
                end else begin
                    ptr_we    = 1'b1;
                    upd.count = cur.count - CNT_W'(1);
                    upd.head  = step_up(cur.head);
                    if (cur.count == CNT_W'(1)) begin
                        map_next[lvl_reg] = 1'b0;
                    end else begin
                        fupd_next = 1'b1;
                        fmem_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Highest-priority non-empty level
    always_comb
    begin
        win = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (map_reg[i]) begin
                win = LVL_W'(i);
            end
        end
    end

    assign new_front = fmem_reg ? store_rd_reg : tid_reg;
    assign win_task  = (fupd_reg && win == lvl_reg) ? new_front : front_mem[win];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            ptr_vld_reg <= '0;
            map_reg     <= '0;
            done_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FRONT);
            if (state_reg == S_PTR) begin
                map_reg <= map_next;
                if (ptr_we) begin
                    ptr_vld_reg[lvl_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            act_reg    <= action;
            tid_reg    <= task_id[TASK_BITS-1:0];
            lvl_reg    <= in_lvl;
            lvl_ok_reg <= in_lvl_ok;
            rd_vld_reg <= ptr_vld_reg[in_lvl];
        end
        if (state_reg == S_PTR) begin
            st_reg   <= st_next;
            fupd_reg <= fupd_next;
            fmem_reg <= fmem_next;
        end
        if (state_reg == S_FRONT) begin
            ready_reg  <= |map_reg;
            task_reg   <= (|map_reg) ? win_task : '0;
            nlvl_reg   <= win;
            lmap_reg   <= map_reg;
            status_reg <= st_reg;
            if (fupd_reg) begin
                front_mem[lvl_reg] <= new_front;
            end
        end
    end

    // Pointer memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PTR && ptr_we) begin
            ptr_mem[lvl_reg] <= upd;
        end
        ptr_rd_reg <= ptr_mem[in_lvl];
    end

    // Task memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PTR && store_we) begin
            store_mem[store_wa] <= tid_reg;
        end
        store_rd_reg <= store_mem[store_ra];
    end

    assign done       = done_reg;
    assign ready_res  = done_reg ? ready_reg : 1'b0;
    assign next_task  = 8'(task_reg);
    assign next_level = 4'(nlvl_reg);
    assign level_map  = 16'(lmap_reg);
    assign status     = status_reg;

    a_done_after_front: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_FRONT)
        else $error("done without a completed transaction");

    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PTR ##1 state_reg == S_FRONT)
        else $error("sequencer skipped a step");

    a_ready_map: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ready_reg == (|lmap_reg))
        else $error("ready flag disagrees with level map");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PTR && ptr_we) |-> upd.count <= CNT_W'(RING_DEPTH))
        else $error("ring count beyond depth");

    a_map_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PTR && ptr_we) |-> map_next[lvl_reg] == (upd.count != '0))
        else $error("bitmap bit disagrees with ring count");

endmodule

[sim/bitmap_multilevel_ready_queue_core_tb.sv]
// Self-checking testbench for bitmap_multilevel_ready_queue_core: directed and random
// add/remove transactions, each result checked against a scoreboard that predicts it.
// Depends on bmrq_pkg and bitmap_multilevel_ready_queue_core.
`timescale 1ns / 100ps

module bitmap_multilevel_ready_queue_core_tb;

    localparam int LEVELS     = 16;
    localparam int RING_DEPTH = 8;

    typedef struct packed {
        logic              ready_bit;
        logic [7:0]        front_task;
        logic [3:0]        front_level;
        logic [15:0]       level_bits;
        bmrq_pkg::status_t stat;
    } sched_report_t;

    class ready_queue_scoreboard;
        logic [7:0]    task_mem [LEVELS][RING_DEPTH];
        int unsigned   head_pos [LEVELS];
        int unsigned   tail_pos [LEVELS];
        int unsigned   fill_cnt [LEVELS];
        logic [15:0]   occupied;
        sched_report_t pending [$];
        int unsigned   n_items;
        int unsigned   n_full;
        int unsigned   n_empty;
        int unsigned   n_all_levels;

        function new();
            occupied = '0;
            for (int i = 0; i < LEVELS; i++) begin
                head_pos[i] = 0;
                tail_pos[i] = 0;
                fill_cnt[i] = 0;
                for (int j = 0; j < RING_DEPTH; j++)
                    task_mem[i][j] = '0;
            end
        endfunction

        function void note_input(bmrq_pkg::action_t act, logic [7:0] tid,
                                 logic [3:0] lvl);
            sched_report_t rep;
            bit            lvl_ok;
            rep    = '0;
            lvl_ok = (lvl < LEVELS);
            rep.stat = bmrq_pkg::ST_DONE;
            if (act == bmrq_pkg::ACT_ADD_BACK || act == bmrq_pkg::ACT_ADD_FRONT) begin
                if (!lvl_ok || fill_cnt[lvl] >= RING_DEPTH)
                    rep.stat = bmrq_pkg::ST_FULL;
                else if (act == bmrq_pkg::ACT_ADD_BACK) begin
                    task_mem[lvl][tail_pos[lvl]] = tid;
                    tail_pos[lvl] = (tail_pos[lvl] + 1) % RING_DEPTH;
                    fill_cnt[lvl]++;
                    occupied[lvl] = 1'b1;
                end else begin
                    head_pos[lvl] = (head_pos[lvl] + RING_DEPTH - 1) % RING_DEPTH;
                    task_mem[lvl][head_pos[lvl]] = tid;
                    fill_cnt[lvl]++;
                    occupied[lvl] = 1'b1;
                end
            end else if (act == bmrq_pkg::ACT_REMOVE) begin
                if (!lvl_ok || fill_cnt[lvl] == 0)
                    rep.stat = bmrq_pkg::ST_EMPTY;
                else begin
                    fill_cnt[lvl]--;
                    head_pos[lvl] = (head_pos[lvl] + 1) % RING_DEPTH;
                    if (fill_cnt[lvl] == 0)
                        occupied[lvl] = 1'b0;
                end
            end
            for (int i = 0; i < LEVELS; i++) begin
                if (occupied[i]) begin
                    rep.ready_bit   = 1'b1;
                    rep.front_level = i[3:0];
                    rep.front_task  = task_mem[i][head_pos[i]];
                    break;
                end
            end
            rep.level_bits = occupied;
            pending.push_back(rep);
            n_items++;
            if (rep.stat == bmrq_pkg::ST_FULL)
                n_full++;
            if (rep.stat == bmrq_pkg::ST_EMPTY)
                n_empty++;
            if (&occupied)
                n_all_levels++;
        endfunction

        function int check_result(sched_report_t got);
            sched_report_t exp_rep;
            int            errs;
            errs = 0;
            if (pending.size() == 0) begin
                $display("%0t: result with no transaction pending", $time);
                return 1;
            end
            exp_rep = pending.pop_front();
            if (got.ready_bit !== exp_rep.ready_bit) begin
                $display("%0t: ready_res expected %0d actual %0d",
                         $time, exp_rep.ready_bit, got.ready_bit);
                errs++;
            end
            if (got.front_task !== exp_rep.front_task) begin
                $display("%0t: next_task expected %0d actual %0d",
                         $time, exp_rep.front_task, got.front_task);
                errs++;
            end
            if (got.front_level !== exp_rep.front_level) begin
                $display("%0t: next_level expected %0d actual %0d",
                         $time, exp_rep.front_level, got.front_level);
                errs++;
            end
            if (got.level_bits !== exp_rep.level_bits) begin
                $display("%0t: level_map expected %h actual %h",
                         $time, exp_rep.level_bits, got.level_bits);
                errs++;
            end
            if (got.stat !== exp_rep.stat) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_rep.stat, got.stat);
                errs++;
            end
            return errs;
        endfunction
    endclass

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic [1:0]  action  = bmrq_pkg::ACT_NONE;
    logic [7:0]  task_id = '0;
    logic [3:0]  level   = '0;
    logic        busy;
    logic        done;
    logic        ready_res;
    logic [7:0]  next_task;
    logic [3:0]  next_level;
    logic [15:0] level_map;
    logic [1:0]  status;

    ready_queue_scoreboard sb;
    int unsigned           fail_cnt  = 0;
    int unsigned           burst_left = 0;

    bitmap_multilevel_ready_queue_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .task_id    (task_id),
        .level      (level),
        .done       (done),
        .ready_res  (ready_res),
        .next_task  (next_task),
        .next_level (next_level),
        .level_map  (level_map),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            fail_cnt += sb.check_result({ready_res, next_task, next_level, level_map, status});
    end

    // sender pacing: bursts of random length, random gaps, some long gap-free runs
    task automatic pace();
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    task automatic send_item(bmrq_pkg::action_t act, logic [7:0] tid, logic [3:0] lvl);
        pace();
        start   <= 1'b1;
        action  <= act;
        task_id <= tid;
        level   <= lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(act, tid, lvl);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bmrq_pkg::action_t act;
        logic [3:0]        lvl;
        int                pick;
        int                add_pct;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, wrap on both ends, full and empty rejections
        send_item(bmrq_pkg::ACT_NONE, 8'hFF, 4'd0);
        send_item(bmrq_pkg::ACT_REMOVE, 8'h00, 4'd0);
        send_item(bmrq_pkg::ACT_ADD_BACK, 8'hFF, 4'd15);
        send_item(bmrq_pkg::ACT_ADD_FRONT, 8'h00, 4'd15);
        for (int i = 0; i < 6; i++)
            send_item(bmrq_pkg::ACT_ADD_BACK, 8'h01 << i, 4'd15);
        send_item(bmrq_pkg::ACT_ADD_BACK, 8'h77, 4'd15);
        send_item(bmrq_pkg::ACT_ADD_FRONT, 8'h88, 4'd15);
        send_item(bmrq_pkg::ACT_ADD_BACK, 8'hA5, 4'd0);
        send_item(bmrq_pkg::ACT_ADD_FRONT, 8'h5A, 4'd0);
        send_item(bmrq_pkg::ACT_REMOVE, 8'h00, 4'd0);
        send_item(bmrq_pkg::ACT_REMOVE, 8'h00, 4'd0);
        send_item(bmrq_pkg::ACT_REMOVE, 8'h00, 4'd0);
        send_item(bmrq_pkg::ACT_REMOVE, 8'hFF, 4'd15);
        send_item(bmrq_pkg::ACT_REMOVE, 8'hFF, 4'd15);
        send_item(bmrq_pkg::ACT_ADD_BACK, 8'h3C, 4'd15);
        send_item(bmrq_pkg::ACT_ADD_BACK, 8'hC3, 4'd15);
        send_item(bmrq_pkg::ACT_NONE, 8'h00, 4'd7);
        drain();

        // random: alternate fill-heavy and remove-heavy phases
        for (int ph = 0; ph < 6; ph++) begin
            add_pct = (ph % 2 == 0) ? 65 : 30;
            for (int n = 0; n < 200; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct)
                    act = (pick % 2 == 0) ? bmrq_pkg::ACT_ADD_BACK
                                          : bmrq_pkg::ACT_ADD_FRONT;
                else if (pick < 90)
                    act = bmrq_pkg::ACT_REMOVE;
                else
                    act = bmrq_pkg::ACT_NONE;
                lvl = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
                send_item(act, 8'($urandom_range(0, 255)), lvl);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        $display("Ran %0d transactions: %0d adds to a full level, %0d removes from an empty one,",
                 sb.n_items, sb.n_full, sb.n_empty);
        $display("and %0d results with every level occupied.", sb.n_all_levels);
        if (fail_cnt == 0 && sb.pending.size() == 0)
            $display("bitmap_multilevel_ready_queue_core_tb passed");
        else
            $display("bitmap_multilevel_ready_queue_core_tb failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("bitmap_multilevel_ready_queue_core_tb failed");
        $finish;
    end

endmodule
